### design/sfla_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfla_pkg
// Shared types, codes and size-class helpers for the size-class block cache.
// ----------------------------------------------------------------------------
package sfla_pkg;

    localparam int NUM_CLASSES     = 8;
    localparam int MIN_CLASS_BYTES = 32;
    localparam int HEADER_BYTES    = 16;
    localparam int STACK_DEPTH_DEF = 64;
    localparam int ADDR_WIDTH_DEF  = 32;

    localparam int CLASS_W   = 3;
    localparam int SIZE_W    = 12;
    localparam int REQ_W     = 13;
    localparam int TOTAL_W   = 14;
    localparam int MAX_TOTAL = MIN_CLASS_BYTES << (NUM_CLASSES - 1);

    typedef logic [1:0] t_op;
    localparam t_op OP_ALLOC  = 2'd0;
    localparam t_op OP_FREE   = 2'd1;
    localparam t_op OP_RESIZE = 2'd2;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_IGNORED   = 2'd1,
        ST_TOO_LARGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic slot_free;
    } t_dp_status;

    // Smallest class whose block holds payload plus header; top class otherwise.
    function automatic logic [CLASS_W-1:0] class_of(input logic [REQ_W-1:0] payload);
        logic [TOTAL_W-1:0] total;
        logic [CLASS_W-1:0] c;
        logic               found;
        total = TOTAL_W'(payload) + TOTAL_W'(HEADER_BYTES);
        c     = CLASS_W'(NUM_CLASSES - 1);
        found = 1'b0;
        for (int k = 0; k < NUM_CLASSES; k++) begin
            if (!found && total <= TOTAL_W'(MIN_CLASS_BYTES << k)) begin
                c     = CLASS_W'(k);
                found = 1'b1;
            end
        end
        return c;
    endfunction

    function automatic logic too_large(input logic [REQ_W-1:0] payload);
        logic [TOTAL_W-1:0] total;
        total = TOTAL_W'(payload) + TOTAL_W'(HEADER_BYTES);
        return total > TOTAL_W'(MAX_TOTAL);
    endfunction

endpackage
`default_nettype wire

### design/sfla_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfla_ctrl
// Sequencer: capture a transaction, run its stack access, hand off the result.
// ----------------------------------------------------------------------------
module sfla_ctrl
    import sfla_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_dp_status i_dp_status,
    output t_cmd            o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_stall  = 1'b1;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                // once the output slot is free, hand off the result and take the next transaction in the same cycle
                if (i_dp_status.slot_free) begin
                    o_cmd.load = 1'b1;
                    o_in_stall = 1'b0;
                    if (i_in_valid) begin
                        o_cmd.capture = 1'b1;
                        n_state       = S_EXEC;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

### design/sfla_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfla_datapath
// Input capture, decision logic, per-class fill counters, stack memory and
// output register.
// ----------------------------------------------------------------------------
module sfla_datapath
    import sfla_pkg::*;
#(
    parameter int ADDR_WIDTH  = ADDR_WIDTH_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_dp_status                 o_dp_status,
    input  wire logic [1:0]            i_op,
    input  wire logic [ADDR_WIDTH-1:0] i_block_addr,
    input  wire logic                  i_header_valid,
    input  wire logic [SIZE_W-1:0]     i_recorded_size,
    input  wire logic [REQ_W-1:0]      i_request_size,
    input  wire logic [ADDR_WIDTH-1:0] i_spare_addr,
    input  wire logic                  i_out_stall,
    output logic                       o_out_valid,
    output logic [1:0]                 o_status,
    output logic [ADDR_WIDTH-1:0]      o_result_addr,
    output logic                       o_took_spare,
    output logic                       o_release_valid,
    output logic [ADDR_WIDTH-1:0]      o_release_addr,
    output logic [SIZE_W-1:0]          o_copy_len,
    output logic                       o_header_write,
    output logic [SIZE_W-1:0]          o_header_size,
    output logic [CLASS_W-1:0]         o_size_class,
    output logic                       o_in_place
);

    localparam int CW        = $clog2(STACK_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_CLASSES * STACK_DEPTH;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    // captured transaction
    t_op                   r_op;
    logic [ADDR_WIDTH-1:0] r_blk;
    logic                  r_marked;
    logic [SIZE_W-1:0]     r_rec;
    logic [REQ_W-1:0]      r_req;
    logic [ADDR_WIDTH-1:0] r_spare;
    logic [CLASS_W-1:0]    r_nc;
    logic [CLASS_W-1:0]    r_oc;
    logic                  r_req_big;
    logic                  r_rec_big;

    logic [CW-1:0]         r_count [NUM_CLASSES];
    logic [ADDR_WIDTH-1:0] r_stack_mem [MEM_DEPTH];
    logic [ADDR_WIDTH-1:0] r_rdata;

    // decision, registered at the access cycle
    t_status               r_res_status;
    logic                  r_res_pop;
    logic                  r_res_spare;
    logic                  r_res_release;
    logic                  r_res_in_place;
    logic                  r_res_hdr;
    logic [SIZE_W-1:0]     r_res_copy;

    logic                  r_out_valid;
    t_status               r_out_status;
    logic [ADDR_WIDTH-1:0] r_out_result;
    logic                  r_out_took_spare;
    logic                  r_out_release;
    logic [ADDR_WIDTH-1:0] r_out_release_addr;
    logic [SIZE_W-1:0]     r_out_copy;
    logic                  r_out_hdr;
    logic [SIZE_W-1:0]     r_out_hdr_size;
    logic [CLASS_W-1:0]    r_out_class;
    logic                  r_out_in_place;

    logic                  blk_nz;
    logic                  is_alloc;
    logic                  is_free;
    logic                  is_move;
    logic                  do_alloc;
    logic                  do_free;
    logic                  keep_block;
    logic                  pop;
    logic                  push;
    logic [CW-1:0]         cnt_n;
    logic [CW-1:0]         cnt_o;
    t_status               status;
    logic [SIZE_W-1:0]     copy_len;
    logic [MEM_AW-1:0]     raddr;
    logic [MEM_AW-1:0]     waddr;

    always_comb begin
        blk_nz   = r_blk != '0;
        is_alloc = (r_op == OP_ALLOC) || (r_op == OP_RESIZE && !blk_nz) ||
                   (r_op == OP_RESIZE && r_req != '0 && !r_marked);
        is_free  = !is_alloc && ((r_op == OP_FREE) || (r_op == OP_RESIZE && r_req == '0));
        is_move  = !is_alloc && r_op == OP_RESIZE && r_req != '0;

        do_alloc   = 1'b0;
        do_free    = 1'b0;
        keep_block = 1'b0;
        status     = ST_DONE;
        if (is_alloc) begin
            if (r_req_big) begin
                status = ST_TOO_LARGE;
            end else begin
                do_alloc = 1'b1;
            end
        end else if (is_free) begin
            if (!blk_nz || !r_marked) begin
                status = ST_IGNORED;
            end else if (r_rec_big) begin
                status = ST_TOO_LARGE;
            end else begin
                do_free = 1'b1;
            end
        end else if (is_move) begin
            if (r_rec_big || r_req_big) begin
                status = ST_TOO_LARGE;
            end else if (r_oc == r_nc) begin
                keep_block = 1'b1;
            end else begin
                do_alloc = 1'b1;
                do_free  = 1'b1;
            end
        end else begin
            status = ST_IGNORED;
        end

        cnt_n = r_count[r_nc];
        cnt_o = r_count[r_oc];
        pop   = do_alloc && cnt_n != '0;
        push  = do_free && cnt_o != CW'(STACK_DEPTH);

        if ({1'b0, r_rec} < r_req) begin
            copy_len = r_rec;
        end else begin
            copy_len = r_req[SIZE_W-1:0];
        end
        if (!(is_move && do_alloc)) begin
            copy_len = '0;
        end

        raddr = MEM_AW'(r_nc) * MEM_AW'(STACK_DEPTH) + MEM_AW'(cnt_n - CW'(1));
        waddr = MEM_AW'(r_oc) * MEM_AW'(STACK_DEPTH) + MEM_AW'(cnt_o);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op      <= i_op;
            r_blk     <= i_block_addr;
            r_marked  <= i_header_valid;
            r_rec     <= i_recorded_size;
            r_req     <= i_request_size;
            r_spare   <= i_spare_addr;
            r_nc      <= class_of(i_request_size);
            r_oc      <= class_of({1'b0, i_recorded_size});
            r_req_big <= too_large(i_request_size);
            r_rec_big <= too_large({1'b0, i_recorded_size});
        end
    end

    // pop and push of a moving resize always hit different classes
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && pop) begin
            r_rdata <= r_stack_mem[raddr];
        end
        if (i_cmd.exec && push) begin
            r_stack_mem[waddr] <= r_blk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_count[c] <= '0;
            end
        end else if (i_cmd.exec) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                if (pop && r_nc == CLASS_W'(c)) begin
                    r_count[c] <= r_count[c] - CW'(1);
                end else if (push && r_oc == CLASS_W'(c)) begin
                    r_count[c] <= r_count[c] + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res_status   <= status;
            r_res_pop      <= pop;
            r_res_spare    <= do_alloc && !pop;
            r_res_release  <= do_free && !push;
            r_res_in_place <= keep_block;
            r_res_hdr      <= do_alloc || keep_block;
            r_res_copy     <= copy_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_status       <= r_res_status;
            if (r_res_pop) begin
                r_out_result <= r_rdata;
            end else if (r_res_spare) begin
                r_out_result <= r_spare;
            end else if (r_res_in_place) begin
                r_out_result <= r_blk;
            end else begin
                r_out_result <= '0;
            end
            r_out_took_spare   <= r_res_spare;
            r_out_release      <= r_res_release;
            r_out_release_addr <= r_res_release ? r_blk : '0;
            r_out_copy         <= r_res_copy;
            r_out_hdr          <= r_res_hdr;
            r_out_hdr_size     <= r_res_hdr ? r_req[SIZE_W-1:0] : '0;
            r_out_class        <= r_res_hdr ? r_nc : '0;
            r_out_in_place     <= r_res_in_place;
        end
    end

    assign o_dp_status.slot_free = !r_out_valid || !i_out_stall;

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_result_addr   = r_out_result;
    assign o_took_spare    = r_out_took_spare;
    assign o_release_valid = r_out_release;
    assign o_release_addr  = r_out_release_addr;
    assign o_copy_len      = r_out_copy;
    assign o_header_write  = r_out_hdr;
    assign o_header_size   = r_out_hdr_size;
    assign o_size_class    = r_out_class;
    assign o_in_place      = r_out_in_place;

endmodule
`default_nettype wire

### design/size_class_free_list_allocator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// size_class_free_list_allocator_top
// Segregated free-list block cache with eight power-of-two size classes.
// ----------------------------------------------------------------------------
// Each transaction (allocate, free or resize) is first captured and classified,
// then runs its stack memory access, which reads a popped entry and writes a
// pushed one through its single read and single write port. The result enters
// the output register, once that register is free, in the same cycle the next
// transaction is accepted; no new transaction is taken during a stack access.
// The fill counters clear at reset; the stack memory needs no clearing, since
// a pop only ever reads an entry that a push has written.
module size_class_free_list_allocator_top
    import sfla_pkg::*;
#(
    parameter int ADDR_WIDTH  = ADDR_WIDTH_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [1:0]            i_op,
    input  wire logic [ADDR_WIDTH-1:0] i_block_addr,
    input  wire logic                  i_header_valid,
    input  wire logic [SIZE_W-1:0]     i_recorded_size,
    input  wire logic [REQ_W-1:0]      i_request_size,
    input  wire logic [ADDR_WIDTH-1:0] i_spare_addr,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [1:0]                 o_status,
    output logic [ADDR_WIDTH-1:0]      o_result_addr,
    output logic                       o_took_spare,
    output logic                       o_release_valid,
    output logic [ADDR_WIDTH-1:0]      o_release_addr,
    output logic [SIZE_W-1:0]          o_copy_len,
    output logic                       o_header_write,
    output logic [SIZE_W-1:0]          o_header_size,
    output logic [CLASS_W-1:0]         o_size_class,
    output logic                       o_in_place
);

    t_cmd       cmd;
    t_dp_status dp_status;

    sfla_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_dp_status (dp_status),
        .o_cmd       (cmd)
    );

    sfla_datapath #(
        .ADDR_WIDTH  (ADDR_WIDTH),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_dp_status     (dp_status),
        .i_op            (i_op),
        .i_block_addr    (i_block_addr),
        .i_header_valid  (i_header_valid),
        .i_recorded_size (i_recorded_size),
        .i_request_size  (i_request_size),
        .i_spare_addr    (i_spare_addr),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_result_addr   (o_result_addr),
        .o_took_spare    (o_took_spare),
        .o_release_valid (o_release_valid),
        .o_release_addr  (o_release_addr),
        .o_copy_len      (o_copy_len),
        .o_header_write  (o_header_write),
        .o_header_size   (o_header_size),
        .o_size_class    (o_size_class),
        .o_in_place      (o_in_place)
    );

endmodule
`default_nettype wire

### design/sfla_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfla_checker
// Port-level checks on the block cache, bound to the top level.
// ----------------------------------------------------------------------------
module sfla_checker
    import sfla_pkg::*;
#(
    parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_valid,
    input wire logic                  o_in_stall,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_stall,
    input wire logic [1:0]            o_status,
    input wire logic [ADDR_WIDTH-1:0] o_result_addr,
    input wire logic                  o_took_spare,
    input wire logic                  o_release_valid,
    input wire logic [SIZE_W-1:0]     o_copy_len,
    input wire logic                  o_header_write,
    input wire logic                  o_in_place
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result_addr))
        else $error("stalled result changed");

    // the stack access cycle follows every accepted transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("transaction accepted during stack access");

    a_too_large_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_TOO_LARGE |->
            o_result_addr == '0 && !o_header_write && !o_release_valid && !o_took_spare)
        else $error("too-large result carries side effects");

    a_in_place_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_in_place |->
            o_header_write && !o_took_spare && !o_release_valid && o_copy_len == '0)
        else $error("in-place resize reports a move");

    a_spare_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_took_spare |-> o_header_write && o_status == ST_DONE && !o_in_place)
        else $error("spare block taken outside an allocation");

endmodule

bind size_class_free_list_allocator_top sfla_checker #(
    .ADDR_WIDTH (ADDR_WIDTH)
) u_sfla_checker (.*);
`default_nettype wire

### tb/alloc_result_checker.sv
// ----------------------------------------------------------------------------
// alloc_result_checker
// Watches both channels of the size-class block cache. Keeps its own copy of
// the per-class free stacks, predicts the result of every accepted transaction
// and compares each returned result, field by field, with the oldest
// prediction.
// ----------------------------------------------------------------------------
module alloc_result_checker
    import sfla_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    input  wire logic                      i_in_stall,
    input  wire logic [1:0]                i_op,
    input  wire logic [ADDR_WIDTH_DEF-1:0] i_block_addr,
    input  wire logic                      i_header_valid,
    input  wire logic [SIZE_W-1:0]         i_recorded_size,
    input  wire logic [REQ_W-1:0]          i_request_size,
    input  wire logic [ADDR_WIDTH_DEF-1:0] i_spare_addr,
    input  wire logic                      i_out_valid,
    input  wire logic                      i_out_stall,
    input  wire logic [1:0]                i_status,
    input  wire logic [ADDR_WIDTH_DEF-1:0] i_result_addr,
    input  wire logic                      i_took_spare,
    input  wire logic                      i_release_valid,
    input  wire logic [ADDR_WIDTH_DEF-1:0] i_release_addr,
    input  wire logic [SIZE_W-1:0]         i_copy_len,
    input  wire logic                      i_header_write,
    input  wire logic [SIZE_W-1:0]         i_header_size,
    input  wire logic [CLASS_W-1:0]        i_size_class,
    input  wire logic                      i_in_place,
    output int                             o_pending,
    output int                             o_errors
);

    typedef struct packed {
        logic [1:0]                status;
        logic [ADDR_WIDTH_DEF-1:0] result_addr;
        logic                      took_spare;
        logic                      release_valid;
        logic [ADDR_WIDTH_DEF-1:0] release_addr;
        logic [SIZE_W-1:0]         copy_len;
        logic                      header_write;
        logic [SIZE_W-1:0]         header_size;
        logic [CLASS_W-1:0]        size_class;
        logic                      in_place;
    } t_outcome;

    logic [ADDR_WIDTH_DEF-1:0] cached_blocks [NUM_CLASSES][STACK_DEPTH_DEF];
    int unsigned               cached_count [NUM_CLASSES];
    t_outcome                  pending_outcomes [$];
    t_outcome                  want;
    int                        outstanding = 0;
    int                        error_count = 0;

    assign o_pending = outstanding;
    assign o_errors  = error_count;

    initial begin
        foreach (cached_count[c]) cached_count[c] = 0;
    end

    function automatic logic [CLASS_W-1:0] class_for(input int unsigned payload);
        for (int c = 0; c < NUM_CLASSES; c++) begin
            if (payload + HEADER_BYTES <= (MIN_CLASS_BYTES << c)) return CLASS_W'(c);
        end
        return CLASS_W'(NUM_CLASSES - 1);
    endfunction

    function automatic logic oversize(input int unsigned payload);
        return payload + HEADER_BYTES > MAX_TOTAL;
    endfunction

    // Pop a cached block of the class, or fall back to the spare block.
    function automatic void take_block(inout t_outcome o, input int unsigned size,
                                       input logic [ADDR_WIDTH_DEF-1:0] spare);
        logic [CLASS_W-1:0] c;
        c = class_for(size);
        if (cached_count[c] > 0) begin
            cached_count[c]--;
            o.result_addr = cached_blocks[c][cached_count[c]];
        end else begin
            o.result_addr = spare;
            o.took_spare  = 1'b1;
        end
        o.header_write = 1'b1;
        o.header_size  = SIZE_W'(size);
        o.size_class   = c;
    endfunction

    // Push onto the class stack, or hand the block back when the stack is full.
    function automatic void give_back(inout t_outcome o, input logic [ADDR_WIDTH_DEF-1:0] blk,
                                      input logic [CLASS_W-1:0] c);
        if (cached_count[c] < STACK_DEPTH_DEF) begin
            cached_blocks[c][cached_count[c]] = blk;
            cached_count[c]++;
        end else begin
            o.release_valid = 1'b1;
            o.release_addr  = blk;
        end
    endfunction

    function automatic t_outcome step_cache(input t_op op, input logic [ADDR_WIDTH_DEF-1:0] blk,
                                            input logic marked, input logic [SIZE_W-1:0] rec,
                                            input logic [REQ_W-1:0] req,
                                            input logic [ADDR_WIDTH_DEF-1:0] spare);
        t_outcome           o;
        logic [CLASS_W-1:0] old_c;
        logic [CLASS_W-1:0] new_c;
        o = '0;
        if (op == OP_ALLOC || (op == OP_RESIZE && blk == '0)
                || (op == OP_RESIZE && req != '0 && !marked)) begin
            if (oversize(req)) o.status = ST_TOO_LARGE;
            else take_block(o, req, spare);
        end else if (op == OP_FREE || op == OP_RESIZE) begin
            if (op == OP_FREE || req == '0) begin
                if (blk == '0 || !marked) o.status = ST_IGNORED;
                else if (oversize(rec)) o.status = ST_TOO_LARGE;
                else give_back(o, blk, class_for(rec));
            end else if (oversize(rec) || oversize(req)) begin
                o.status = ST_TOO_LARGE;
            end else begin
                old_c = class_for(rec);
                new_c = class_for(req);
                if (old_c == new_c) begin
                    o.result_addr  = blk;
                    o.header_write = 1'b1;
                    o.header_size  = SIZE_W'(req);
                    o.size_class   = new_c;
                    o.in_place     = 1'b1;
                end else begin
                    take_block(o, req, spare);
                    o.copy_len = SIZE_W'((rec < req) ? rec : req);
                    give_back(o, blk, old_c);
                end
            end
        end else begin
            o.status = ST_IGNORED;
        end
        return o;
    endfunction

    // Queue a prediction behind the ones still in flight.
    function automatic void append_outcome(input t_outcome o);
        pending_outcomes.insert(pending_outcomes.size(), o);
    endfunction

    task automatic report(input string what);
        $display("t=%0t alloc checker: %s", $time, what);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_v);
        if (got !== exp_v) report($sformatf("%s got %0h, want %0h", name, got, exp_v));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (cached_count[c]) cached_count[c] = 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                append_outcome(step_cache(i_op, i_block_addr, i_header_valid,
                                          i_recorded_size, i_request_size,
                                          i_spare_addr));
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_outcomes.size() == 0) begin
                    report("result transaction with no request waiting");
                end else begin
                    want = pending_outcomes.pop_front();
                    check_field("status", 32'(i_status), 32'(want.status));
                    check_field("result_addr", 32'(i_result_addr), 32'(want.result_addr));
                    check_field("took_spare", 32'(i_took_spare), 32'(want.took_spare));
                    check_field("release_valid", 32'(i_release_valid),
                                32'(want.release_valid));
                    check_field("release_addr", 32'(i_release_addr), 32'(want.release_addr));
                    check_field("copy_len", 32'(i_copy_len), 32'(want.copy_len));
                    check_field("header_write", 32'(i_header_write), 32'(want.header_write));
                    check_field("header_size", 32'(i_header_size), 32'(want.header_size));
                    check_field("size_class", 32'(i_size_class), 32'(want.size_class));
                    check_field("in_place", 32'(i_in_place), 32'(want.in_place));
                end
            end
            outstanding = pending_outcomes.size();
        end
    end

endmodule

### tb/size_class_free_list_allocator_top_test.sv
// ----------------------------------------------------------------------------
// size_class_free_list_allocator_top_test
// Drives allocate, free and resize transactions into the size-class block
// cache: a directed pass over the corner cases, then phases of random traffic
// that fill class stacks to overflow and drain them to empty, with random gaps
// on the input channel and random stalls on the result channel. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module size_class_free_list_allocator_top_test;
    import sfla_pkg::*;

    localparam int  RANDOM_ITEMS = 950;
    localparam t_op OP_UNUSED    = 2'd3;

    typedef enum logic [1:0] {
        PH_FILL,
        PH_DRAIN,
        PH_MIXED
    } t_phase_kind;

    logic                      clk           = 1'b0;
    logic                      rst_n         = 1'b0;
    logic                      in_valid      = 1'b0;
    logic                      in_stall;
    logic [1:0]                op            = '0;
    logic [ADDR_WIDTH_DEF-1:0] block_addr    = '0;
    logic                      header_valid  = 1'b0;
    logic [SIZE_W-1:0]         recorded_size = '0;
    logic [REQ_W-1:0]          request_size  = '0;
    logic [ADDR_WIDTH_DEF-1:0] spare_addr    = '0;
    logic                      out_valid;
    logic                      out_stall     = 1'b0;
    logic [1:0]                status;
    logic [ADDR_WIDTH_DEF-1:0] result_addr;
    logic                      took_spare;
    logic                      release_valid;
    logic [ADDR_WIDTH_DEF-1:0] release_addr;
    logic [SIZE_W-1:0]         copy_len;
    logic                      header_write;
    logic [SIZE_W-1:0]         header_size;
    logic [CLASS_W-1:0]        size_class;
    logic                      in_place;
    int                        pending;
    int                        errors;

    always #5 clk = ~clk;

    size_class_free_list_allocator_top u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_op            (op),
        .i_block_addr    (block_addr),
        .i_header_valid  (header_valid),
        .i_recorded_size (recorded_size),
        .i_request_size  (request_size),
        .i_spare_addr    (spare_addr),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_status        (status),
        .o_result_addr   (result_addr),
        .o_took_spare    (took_spare),
        .o_release_valid (release_valid),
        .o_release_addr  (release_addr),
        .o_copy_len      (copy_len),
        .o_header_write  (header_write),
        .o_header_size   (header_size),
        .o_size_class    (size_class),
        .o_in_place      (in_place)
    );

    alloc_result_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_op            (op),
        .i_block_addr    (block_addr),
        .i_header_valid  (header_valid),
        .i_recorded_size (recorded_size),
        .i_request_size  (request_size),
        .i_spare_addr    (spare_addr),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_status        (status),
        .i_result_addr   (result_addr),
        .i_took_spare    (took_spare),
        .i_release_valid (release_valid),
        .i_release_addr  (release_addr),
        .i_copy_len      (copy_len),
        .i_header_write  (header_write),
        .i_header_size   (header_size),
        .i_size_class    (size_class),
        .i_in_place      (in_place),
        .o_pending       (pending),
        .o_errors        (errors)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(19, 0);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Payload size that lands in class c, with the class edges favored.
    function automatic logic [REQ_W-1:0] payload_in_class(input int unsigned c);
        int unsigned lo;
        int unsigned hi;
        lo = (c == 0) ? 0 : (MIN_CLASS_BYTES << (c - 1)) - HEADER_BYTES + 1;
        hi = (MIN_CLASS_BYTES << c) - HEADER_BYTES;
        case ($urandom_range(3, 0))
            0:       return REQ_W'(lo);
            1:       return REQ_W'(hi);
            default: return REQ_W'($urandom_range(hi, lo));
        endcase
    endfunction

    function automatic logic [ADDR_WIDTH_DEF-1:0] rand_block();
        logic [ADDR_WIDTH_DEF-1:0] a;
        a = $urandom;
        if ($urandom_range(15, 0) == 0) a = '1;
        if (a == '0) a = 1;
        return a;
    endfunction

    task automatic issue(input t_op op_v, input logic [ADDR_WIDTH_DEF-1:0] blk_v,
                         input logic marked_v, input logic [SIZE_W-1:0] rec_v,
                         input logic [REQ_W-1:0] req_v,
                         input logic [ADDR_WIDTH_DEF-1:0] spare_v);
        @(negedge clk);
        op            <= op_v;
        block_addr    <= blk_v;
        header_valid  <= marked_v;
        recorded_size <= rec_v;
        request_size  <= req_v;
        spare_addr    <= spare_v;
        in_valid      <= 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic hold_off(input int unsigned n);
        if (n != 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // Result-side back-pressure, with occasional long stretches of none.
    initial begin
        forever begin
            if ($urandom_range(9, 0) == 0) repeat ($urandom_range(300, 100)) @(negedge clk);
            else repeat (idle_len() + 1) @(negedge clk);
            out_stall <= 1'b1;
            repeat (idle_len() + 1) @(negedge clk);
            out_stall <= 1'b0;
        end
    end

    initial begin
        #10_000_000;
        $display("size_class_free_list_allocator_top_test: done, errors");
        $finish;
    end

    initial begin
        int unsigned         sent;
        int unsigned         len;
        int unsigned         hot;
        int unsigned         c;
        int unsigned         r;
        bit                  first;
        bit                  steady;
        t_phase_kind         kind;
        t_op                 op_pick;
        logic [REQ_W-1:0]    req_pick;
        logic [CLASS_W-1:0]  old_c;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Directed corner cases, back to back.
        issue(OP_ALLOC, 32'h0000_1234, 1'b0, 12'd0, 13'd0, 32'h0000_0001);
        issue(OP_FREE, 32'hFFFF_FFFF, 1'b1, 12'd0, 13'd0, 32'h0);
        issue(OP_ALLOC, 32'h0, 1'b0, 12'd0, 13'd16, 32'h0000_0040);
        issue(OP_ALLOC, 32'h0, 1'b0, 12'd0, 13'd17, 32'hFFFF_FFFF);
        issue(OP_ALLOC, 32'h0, 1'b0, 12'd0, 13'd4080, 32'h8000_0000);
        issue(OP_ALLOC, 32'h0, 1'b0, 12'd0, 13'd4081, 32'h0000_1000);
        issue(OP_ALLOC, 32'hFFFF_FFFF, 1'b1, 12'hFFF, 13'h1FFF, 32'hFFFF_FFFF);
        issue(OP_FREE, 32'h0, 1'b1, 12'd100, 13'd0, 32'h0);
        issue(OP_FREE, 32'h0000_2000, 1'b0, 12'd100, 13'd0, 32'h0);
        issue(OP_FREE, 32'h0000_3000, 1'b1, 12'hFFF, 13'd0, 32'h0);
        issue(OP_FREE, 32'hA5A5_0000, 1'b1, 12'd4080, 13'd0, 32'h0);
        issue(OP_RESIZE, 32'h0, 1'b1, 12'd50, 13'd100, 32'h0000_5000);
        issue(OP_RESIZE, 32'h0000_6000, 1'b1, 12'd40, 13'd0, 32'h0000_6100);
        issue(OP_RESIZE, 32'h0000_7000, 1'b0, 12'd40, 13'd0, 32'h0000_7100);
        issue(OP_RESIZE, 32'h0000_8000, 1'b0, 12'd40, 13'd200, 32'h0000_8100);
        issue(OP_RESIZE, 32'h0000_9000, 1'b1, 12'd100, 13'd90, 32'h0000_9100);
        issue(OP_RESIZE, 32'h0000_A000, 1'b1, 12'd100, 13'd1000, 32'h0000_A100);
        issue(OP_RESIZE, 32'h0000_B000, 1'b1, 12'd2000, 13'd20, 32'h0000_B100);
        issue(OP_RESIZE, 32'h0000_C000, 1'b1, 12'd100, 13'd5000, 32'h0000_C100);
        issue(OP_RESIZE, 32'h0000_D000, 1'b1, 12'd4090, 13'd100, 32'h0000_D100);
        issue(OP_UNUSED, 32'hFFFF_FFFF, 1'b1, 12'hFFF, 13'h1FFF, 32'hFFFF_FFFF);
        issue(OP_ALLOC, 32'h0, 1'b0, 12'd0, 13'd4000, 32'h0000_E000);
        settle();

        // Random phases: the first one floods a single class past its depth.
        sent  = 0;
        first = 1'b1;
        while (sent < RANDOM_ITEMS) begin
            hot    = $urandom_range(NUM_CLASSES - 1, 0);
            kind   = first ? PH_FILL : t_phase_kind'($urandom_range(2, 0));
            len    = first ? 150 : $urandom_range(150, 40);
            steady = ($urandom_range(3, 0) == 0);
            for (int unsigned n = 0; n < len && sent < RANDOM_ITEMS; n++) begin
                c = ($urandom_range(3, 0) != 0) ? hot : $urandom_range(NUM_CLASSES - 1, 0);
                if ($urandom_range(99, 0) < 8) begin
                    issue(t_op'($urandom_range(3, 0)), $urandom, 1'($urandom),
                          SIZE_W'($urandom), REQ_W'($urandom), $urandom);
                end else begin
                    r = $urandom_range(99, 0);
                    case (kind)
                        PH_FILL:  op_pick = (r < 70) ? OP_FREE : (r < 85) ? OP_RESIZE : OP_ALLOC;
                        PH_DRAIN: op_pick = (r < 70) ? OP_ALLOC : (r < 85) ? OP_RESIZE : OP_FREE;
                        default:  op_pick = (r < 35) ? OP_ALLOC : (r < 65) ? OP_FREE : OP_RESIZE;
                    endcase
                    case (op_pick)
                        OP_ALLOC: begin
                            req_pick = ($urandom_range(29, 0) == 0)
                                ? REQ_W'($urandom_range(8191, 4081)) : payload_in_class(c);
                            issue(OP_ALLOC, $urandom, 1'($urandom), SIZE_W'($urandom),
                                  req_pick, $urandom);
                        end
                        OP_FREE: begin
                            issue(OP_FREE, rand_block(), ($urandom_range(9, 0) != 0),
                                  SIZE_W'(payload_in_class(c)), REQ_W'($urandom), $urandom);
                        end
                        default: begin
                            old_c = $urandom_range(1, 0) ? CLASS_W'(c)
                                                          : CLASS_W'($urandom_range(7, 0));
                            r = $urandom_range(19, 0);
                            if (r < 3) req_pick = '0;
                            else if (r < 10) req_pick = payload_in_class(old_c);
                            else if (r == 10) req_pick = REQ_W'($urandom_range(8191, 4081));
                            else req_pick = payload_in_class(c);
                            issue(OP_RESIZE, ($urandom_range(19, 0) == 0) ? '0 : rand_block(),
                                  ($urandom_range(9, 0) != 0),
                                  SIZE_W'(payload_in_class(old_c)), req_pick, $urandom);
                        end
                    endcase
                end
                sent++;
                if (!steady) hold_off(idle_len());
            end
            if (first || $urandom_range(3, 0) == 0) settle();
            first = 1'b0;
        end

        settle();
        repeat (10) @(negedge clk);
        if (errors == 0) begin
            $display("size_class_free_list_allocator_top_test: done, clean");
        end else begin
            $display("size_class_free_list_allocator_top_test: done, errors");
        end
        $finish;
    end

endmodule

### sim.f
design/sfla_pkg.sv
design/sfla_ctrl.sv
design/sfla_datapath.sv
design/size_class_free_list_allocator_top.sv
design/sfla_checker.sv
tb/alloc_result_checker.sv
tb/size_class_free_list_allocator_top_test.sv
